@@ design/phrase_queue_drop_oldest_assert.svh @@
// Assertion macros for the phrase queue block.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef PHRASE_QUEUE_DROP_OLDEST_ASSERT_SVH
`define PHRASE_QUEUE_DROP_OLDEST_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PQDO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PQDO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/pqdo_pkg.sv @@
// Shared constants and types for the phrase queue block.
// No dependencies.
`default_nettype none

package pqdo_pkg;

  localparam int PHRASE_COUNT = 64;
  localparam int MAX_QUEUED   = 14;

  localparam int ENTRY_W = 6;
  localparam int MASK_W  = 64;
  localparam int CNT_W   = $clog2(MAX_QUEUED + 1);
  localparam int IDX_W   = (MAX_QUEUED > 1) ? $clog2(MAX_QUEUED) : 1;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 64;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  localparam logic [ADDR_W-1:0] ADDR_VALID_MASK = '0;

  // Per-cell control: shift takes the neighbor's word, load takes the new word.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/pqdo_cell.sv @@
// One queue slot of the phrase queue chain.
// Depends on pqdo_pkg for the entry width and the control struct.
`default_nettype none

module pqdo_cell import pqdo_pkg::*; (
  input  wire                clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  wire  [ENTRY_W-1:0] load_data_i,
  input  wire  [ENTRY_W-1:0] nbr_data_i,
  output logic [ENTRY_W-1:0] entry_o
);

  logic [ENTRY_W-1:0] entry_q, entry_d;

  // Load wins over shift; otherwise hold.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = load_data_i;
    end else if (ctrl_i.shift) begin
      entry_d = nbr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

@@ design/phrase_queue_drop_oldest.sv @@
// Top level of the phrase queue: control, fill count, result register, APB port.
// Depends on pqdo_pkg, pqdo_cell and phrase_queue_drop_oldest_assert.svh.
//
// Usage: one input word per handshake (in_valid_i / in_stall_o) carries mode,
// phrase, urgent and playing. Every accepted word gives exactly one result word
// on out_valid_o / out_stall_i. The queue is a row of slots; slot 0 is the
// oldest entry and every pop moves the whole row one slot toward it.
// Push, clear, and a tick that does not scan (player busy or gap pending) go
// from idle straight to the emit state, and the next word is taken once their
// result has moved into the result register. A scanning tick pops one entry
// per cycle until an entry with available audio is found or the queue is
// empty; the single-entry pop of the slot row sets that pace.
// The result register frees the core: a finished result waits there while the
// next word is accepted and worked on. If the receiver still stalls when that
// next result is ready, the core holds it and stalls the input side.
// valid_mask is written at byte address 0 of the APB port (64-bit data).
// Reset empties the queue, clears the gap and the mask and drops any result.
`default_nettype none

module phrase_queue_drop_oldest import pqdo_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  // input channel
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [1:0]         mode_i,
  input  wire  [7:0]         phrase_i,
  input  wire                urgent_i,
  input  wire                playing_i,
  // output channel
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic               start_play_o,
  output logic [5:0]         play_phrase_o,
  output logic               stop_play_o,
  output logic               speaking_o,
  output logic [3:0]         queue_count_o,
  // configuration port
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [ADDR_W-1:0]  paddr,
  input  wire  [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic               gap_q, gap_d;
  logic [MASK_W-1:0]  mask_q;
  logic               res_start_q, res_start_d;
  logic [ENTRY_W-1:0] res_phrase_q, res_phrase_d;
  logic               res_stop_q, res_stop_d;
  logic               playing_q, playing_d;
  logic               out_valid_q, out_valid_d;
  logic               out_start_q, out_stop_q, out_speak_q;
  logic [ENTRY_W-1:0] out_phrase_q;
  logic [3:0]         out_count_q;

  logic               accept;
  logic               emit;
  logic               push_ok;
  logic               push_full;
  logic               pop;
  logic [IDX_W-1:0]   load_idx;
  logic [ENTRY_W-1:0] head_entry;

  cell_ctrl_t         ctrl     [MAX_QUEUED];
  logic [ENTRY_W-1:0] entries  [MAX_QUEUED];

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_VALID_MASK) ? mask_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_VALID_MASK) begin
      mask_q <= pwdata;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign emit       = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign head_entry = entries[0];
  assign push_ok    = ({1'b0, phrase_i} < 9'(PHRASE_COUNT)) && (phrase_i < 8'd64);

  // Next state, fill count, gap and pending result
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    gap_d        = gap_q;
    res_start_d  = res_start_q;
    res_phrase_d = res_phrase_q;
    res_stop_d   = res_stop_q;
    playing_d    = playing_q;
    push_full    = 1'b0;
    pop          = 1'b0;
    load_idx     = IDX_W'(fill_q);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_start_d  = 1'b0;
          res_phrase_d = '0;
          res_stop_d   = 1'b0;
          playing_d    = playing_i;
          state_d      = ST_EMIT;
          unique case (mode_i)
            MODE_PUSH: begin
              if (urgent_i) begin
                res_stop_d = 1'b1;
                load_idx   = '0;
                fill_d     = push_ok ? CNT_W'(1) : '0;
              end else if (fill_q == CNT_W'(MAX_QUEUED)) begin
                push_full = push_ok;
                load_idx  = IDX_W'(MAX_QUEUED - 1);
              end else begin
                fill_d = fill_q + CNT_W'(push_ok);
              end
            end
            MODE_TICK: begin
              if (!playing_i) begin
                if (gap_q) begin
                  gap_d = 1'b0;
                end else begin
                  state_d = ST_SCAN;
                end
              end
            end
            MODE_CLEAR: begin
              fill_d = '0;
              gap_d  = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Pop the oldest entry; start it if its audio is available.
        if (fill_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          pop    = 1'b1;
          fill_d = fill_q - CNT_W'(1);
          if (mask_q[head_entry]) begin
            res_start_d  = 1'b1;
            res_phrase_d = head_entry;
            gap_d        = 1'b1;
            state_d      = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      gap_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      gap_q   <= gap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_start_q  <= res_start_d;
    res_phrase_q <= res_phrase_d;
    res_stop_q   <= res_stop_d;
    playing_q    <= playing_d;
  end

  // Slot controls: shift on pop or full push, load at the tail
  always_comb begin
    for (int i = 0; i < MAX_QUEUED; i++) begin
      ctrl[i].shift = pop || push_full;
      ctrl[i].load  = accept && (mode_i == MODE_PUSH) && push_ok
                      && (load_idx == IDX_W'(i));
    end
  end

  // Row of queue slots, slot 0 oldest
  for (genvar g = 0; g < MAX_QUEUED; g++) begin : g_slot
    logic [ENTRY_W-1:0] nbr;
    if (g == MAX_QUEUED - 1) begin : g_last
      assign nbr = entries[g];
    end else begin : g_mid
      assign nbr = entries[g+1];
    end
    pqdo_cell u_slot (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl[g]),
      .load_data_i (phrase_i[ENTRY_W-1:0]),
      .nbr_data_i  (nbr),
      .entry_o     (entries[g])
    );
  end

  // Result register: load on emit, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_start_q  <= res_start_q;
      out_phrase_q <= res_phrase_q;
      out_stop_q   <= res_stop_q;
      out_speak_q  <= playing_q || (fill_q != '0);
      out_count_q  <= 4'(fill_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign start_play_o  = out_start_q;
  assign play_phrase_o = out_phrase_q;
  assign stop_play_o   = out_stop_q;
  assign speaking_o    = out_speak_q;
  assign queue_count_o = out_count_q;

  // Assertions
  `include "phrase_queue_drop_oldest_assert.svh"

  `PQDO_ASSERT(a_scan_pops_one, (state_q == ST_SCAN && fill_q != '0) |=> (fill_q == $past(fill_q) - CNT_W'(1)), "scan step must pop exactly one entry")
  `PQDO_ASSERT(a_start_sets_gap, (state_q == ST_EMIT && res_start_q) |-> gap_q, "started phrase must leave a gap pending")
  `PQDO_ASSERT(a_count_bound, out_valid_o |-> (queue_count_o <= 4'(MAX_QUEUED)), "reported count exceeds queue depth")
  `PQDO_ASSERT(a_speak_nonempty, (out_valid_o && queue_count_o != 4'd0) |-> speaking_o, "non-empty queue must report speaking")

endmodule

`default_nettype wire
